// ===== rtl/core/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants, command codes and the per-item sideband record of the
// lidar point colorizer.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // Image store geometry
    localparam int MAX_ROWS = 512;
    localparam int MAX_COLS = 1024;
    localparam int NPIX     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(NPIX);

    // Fixed-point formats
    localparam int COEF_FRAC_BITS = 16;
    localparam int PT_FRAC_BITS   = 16;

    // Coefficient banks: K is 3x3, E is 3x4, both row-major
    localparam int K_NUM   = 9;
    localparam int E_NUM   = 12;
    localparam int K_IDX_W = $clog2(K_NUM);
    localparam int E_IDX_W = $clog2(E_NUM);

    // Datapath widths
    localparam int PROD_W = 64;                    // 32x32 signed product
    localparam int SUM_W  = PROD_W + 2;            // sum of three products
    localparam int KP_W   = PROD_W - COEF_FRAC_BITS; // floored K product
    localparam int P_W    = KP_W + 2;              // projected coordinate
    localparam int DIV_W  = P_W;                   // divider magnitude width

    // Command codes
    localparam logic [1:0] CMD_COEF    = 2'd0;
    localparam logic [1:0] CMD_PIXEL   = 2'd1;
    localparam logic [1:0] CMD_PROJECT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [9:0]  ROWS_RESET = 10'd480;
    localparam logic [10:0] COLS_RESET = 11'd640;

    // Sideband that travels with every item
    typedef struct packed {
        logic [1:0]  cmd;
        logic        drop;
        logic [4:0]  coef_index;
        logic [31:0] coef_value;
        logic [18:0] pixel_index;
        logic [23:0] rgb;
    } t_side;

endpackage

// ===== rtl/core/lidar_point_colorizer.sv =====
// ----------------------------------------------------------------------------
// lidar_point_colorizer
// Pinhole projection of lidar points into a stored RGB image, with the
// coefficient and pixel loads carried in the same item stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command per transfer:
//   coefficient load, pixel load or point projection. Output channel
//   (o_valid / i_stall) returns exactly one result per item, in order;
//   loads and unused commands return an uncolored, all-zero result.
//   Config port (i_cfg_wr_en / i_cfg_index / i_cfg_wdata) sets the image
//   size in use; write it only while no item is in flight.
//   Throughput: one item per cycle while the receiver does not stall. The
//   divider resolves one quotient bit per stage over DIV_W stages, and the
//   remaining stages do multiply, sum and lookup.
//   Loads take effect at the stage where the loaded value is read, so each
//   item sees exactly the loads that came before it.
//   Reset clears all valid bits and sets the image size to 480 x 640;
//   coefficients and pixels are undefined until loaded.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lidar_point_colorizer
    import lpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [4:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic [18:0]        i_pixel_index,
    input  logic [7:0]         i_pixel_red,
    input  logic [7:0]         i_pixel_green,
    input  logic [7:0]         i_pixel_blue,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_colored,
    output logic [7:0]         o_out_red,
    output logic [7:0]         o_out_green,
    output logic [7:0]         o_out_blue,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [10:0]        i_cfg_wdata
);

    localparam int RC_W  = 44;       // 32-bit row times 12-bit column count
    localparam int IDX_W = RC_W + 1;

    // ------------------------------------------------------------------
    // Global advance: hold everything while a result waits on a stall
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic w_adv;

    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0]  r_rows;
    logic [10:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_wdata[9:0];
                CFG_COLS: r_cols <= i_cfg_wdata;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    t_side r1_side, r2_side, r3_side, r4_side, r5_side;

    logic signed [31:0]       r1_pt   [3];
    logic signed [31:0]       r_e     [E_NUM];
    logic signed [31:0]       r_k     [K_NUM];
    logic signed [PROD_W-1:0] r2_prod [9];
    logic signed [31:0]       r2_eoff [3];
    logic signed [31:0]       r3_cam  [3];
    logic signed [KP_W-1:0]   r4_kp   [9];
    logic signed [P_W-1:0]    r5_p    [3];

    // Capture the input transfer; non-projections and zero points drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side.cmd         <= i_cmd;
            r1_side.drop        <= (i_cmd != CMD_PROJECT) ||
                                   (i_point_x == '0 && i_point_y == '0 && i_point_z == '0);
            r1_side.coef_index  <= i_coef_index;
            r1_side.coef_value  <= i_coef_value;
            r1_side.pixel_index <= i_pixel_index;
            r1_side.rgb         <= {i_pixel_red, i_pixel_green, i_pixel_blue};
            r1_pt[0]            <= i_point_x;
            r1_pt[1]            <= i_point_y;
            r1_pt[2]            <= i_point_z;
        end
    end

    // Load E when the item sits where E is read
    logic                w_e_wr;
    logic [E_IDX_W-1:0]  w_e_sel;

    assign w_e_wr  = w_adv && r1_vld && (r1_side.cmd == CMD_COEF) &&
                     (r1_side.coef_index >= 5'(K_NUM)) &&
                     (r1_side.coef_index < 5'(K_NUM + E_NUM));
    assign w_e_sel = E_IDX_W'(r1_side.coef_index - 5'(K_NUM));

    always_ff @(posedge i_clk) begin
        if (w_e_wr) begin
            r_e[w_e_sel] <= r1_side.coef_value;
        end
    end

    // Stage 2: E times point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_side <= r1_side;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_prod[i*3+k] <= r_e[i*4+k] * r1_pt[k];
                end
                r2_eoff[i] <= r_e[i*4+3];
            end
        end
    end

    // Stage 3: sum, floor, add offset, saturate to camera coordinates
    logic signed [SUM_W-1:0] w_cam_full [3];
    logic signed [31:0]      n_cam      [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cam_full[i] = ((SUM_W'(r2_prod[i*3]) + SUM_W'(r2_prod[i*3+1]) +
                              SUM_W'(r2_prod[i*3+2])) >>> PT_FRAC_BITS) +
                            SUM_W'(r2_eoff[i]);
            if (w_cam_full[i][SUM_W-1:31] == '0 || w_cam_full[i][SUM_W-1:31] == '1) begin
                n_cam[i] = w_cam_full[i][31:0];
            end else if (w_cam_full[i][SUM_W-1]) begin
                n_cam[i] = 32'sh8000_0000;
            end else begin
                n_cam[i] = 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_side <= r2_side;
            r3_cam  <= n_cam;
        end
    end

    // Load K when the item sits where K is read
    logic w_k_wr;

    assign w_k_wr = w_adv && r3_vld && (r3_side.cmd == CMD_COEF) &&
                    (r3_side.coef_index < 5'(K_NUM));

    always_ff @(posedge i_clk) begin
        if (w_k_wr) begin
            r_k[r3_side.coef_index[K_IDX_W-1:0]] <= r3_side.coef_value;
        end
    end

    // Stage 4: K times camera, each product floored on its own
    logic signed [PROD_W-1:0] w_kprod [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                w_kprod[i*3+k] = r_k[i*3+k] * r3_cam[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_side <= r3_side;
            for (int j = 0; j < 9; j++) begin
                r4_kp[j] <= w_kprod[j][PROD_W-1:COEF_FRAC_BITS];
            end
        end
    end

    // Stage 5: sum into projected coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_side <= r4_side;
            for (int i = 0; i < 3; i++) begin
                r5_p[i] <= P_W'(r4_kp[i*3]) + P_W'(r4_kp[i*3+1]) + P_W'(r4_kp[i*3+2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage on magnitudes, both quotients
    // share the depth as divisor
    // ------------------------------------------------------------------
    logic             r_dv_vld  [DIV_W+1];
    t_side            r_dv_side [DIV_W+1];
    logic [DIV_W-1:0] r_dv_num0 [DIV_W+1];
    logic [DIV_W-1:0] r_dv_num1 [DIV_W+1];
    logic [DIV_W-1:0] r_dv_rem0 [DIV_W+1];
    logic [DIV_W-1:0] r_dv_rem1 [DIV_W+1];
    logic [DIV_W-1:0] r_dv_den  [DIV_W+1];
    logic             r_dv_neg0 [DIV_W+1];
    logic             r_dv_neg1 [DIV_W+1];

    logic [DIV_W:0]   w_trial0  [DIV_W];
    logic [DIV_W:0]   w_trial1  [DIV_W];
    logic [DIV_W-1:0] n_dv_num0 [DIV_W];
    logic [DIV_W-1:0] n_dv_num1 [DIV_W];
    logic [DIV_W-1:0] n_dv_rem0 [DIV_W];
    logic [DIV_W-1:0] n_dv_rem1 [DIV_W];

    // One restoring step per stage
    always_comb begin
        for (int j = 0; j < DIV_W; j++) begin
            w_trial0[j] = {r_dv_rem0[j], r_dv_num0[j][DIV_W-1]};
            w_trial1[j] = {r_dv_rem1[j], r_dv_num1[j][DIV_W-1]};
            if (w_trial0[j] >= {1'b0, r_dv_den[j]}) begin
                n_dv_rem0[j] = DIV_W'(w_trial0[j] - {1'b0, r_dv_den[j]});
                n_dv_num0[j] = {r_dv_num0[j][DIV_W-2:0], 1'b1};
            end else begin
                n_dv_rem0[j] = w_trial0[j][DIV_W-1:0];
                n_dv_num0[j] = {r_dv_num0[j][DIV_W-2:0], 1'b0};
            end
            if (w_trial1[j] >= {1'b0, r_dv_den[j]}) begin
                n_dv_rem1[j] = DIV_W'(w_trial1[j] - {1'b0, r_dv_den[j]});
                n_dv_num1[j] = {r_dv_num1[j][DIV_W-2:0], 1'b1};
            end else begin
                n_dv_rem1[j] = w_trial1[j][DIV_W-1:0];
                n_dv_num1[j] = {r_dv_num1[j][DIV_W-2:0], 1'b0};
            end
        end
    end

    // Load magnitudes and signs; zero depth drops the point
    t_side            n_dv_side0;
    logic [DIV_W-1:0] n_mag0, n_mag1, n_magd;

    always_comb begin
        n_dv_side0      = r5_side;
        n_dv_side0.drop = r5_side.drop || (r5_p[2] == '0);
        n_mag0 = r5_p[0][P_W-1] ? DIV_W'(-r5_p[0]) : DIV_W'(r5_p[0]);
        n_mag1 = r5_p[1][P_W-1] ? DIV_W'(-r5_p[1]) : DIV_W'(r5_p[1]);
        n_magd = r5_p[2][P_W-1] ? DIV_W'(-r5_p[2]) : DIV_W'(r5_p[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= DIV_W; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv_vld[0] <= r5_vld;
            for (int j = 0; j < DIV_W; j++) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_side[0] <= n_dv_side0;
            r_dv_num0[0] <= n_mag0;
            r_dv_num1[0] <= n_mag1;
            r_dv_rem0[0] <= '0;
            r_dv_rem1[0] <= '0;
            r_dv_den[0]  <= n_magd;
            r_dv_neg0[0] <= r5_p[0][P_W-1] ^ r5_p[2][P_W-1];
            r_dv_neg1[0] <= r5_p[1][P_W-1] ^ r5_p[2][P_W-1];
            for (int j = 0; j < DIV_W; j++) begin
                r_dv_side[j+1] <= r_dv_side[j];
                r_dv_num0[j+1] <= n_dv_num0[j];
                r_dv_num1[j+1] <= n_dv_num1[j];
                r_dv_rem0[j+1] <= n_dv_rem0[j];
                r_dv_rem1[j+1] <= n_dv_rem1[j];
                r_dv_den[j+1]  <= r_dv_den[j];
                r_dv_neg0[j+1] <= r_dv_neg0[j];
                r_dv_neg1[j+1] <= r_dv_neg1[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quotient stage: apply sign and saturate column and row
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]   w_q0, w_q1;
    logic signed [31:0] n_col, n_row;

    assign w_q0 = r_dv_num0[DIV_W];
    assign w_q1 = r_dv_num1[DIV_W];

    always_comb begin
        if (r_dv_neg0[DIV_W]) begin
            if (w_q0[DIV_W-1:32] != '0 || (w_q0[31] && w_q0[30:0] != '0)) begin
                n_col = 32'sh8000_0000;
            end else begin
                n_col = -w_q0[31:0];
            end
        end else if (w_q0[DIV_W-1:31] != '0) begin
            n_col = 32'sh7fff_ffff;
        end else begin
            n_col = w_q0[31:0];
        end
        if (r_dv_neg1[DIV_W]) begin
            if (w_q1[DIV_W-1:32] != '0 || (w_q1[31] && w_q1[30:0] != '0)) begin
                n_row = 32'sh8000_0000;
            end else begin
                n_row = -w_q1[31:0];
            end
        end else if (w_q1[DIV_W-1:31] != '0) begin
            n_row = 32'sh7fff_ffff;
        end else begin
            n_row = w_q1[31:0];
        end
    end

    logic               r_q_vld;
    t_side              r_q_side;
    logic signed [31:0] r_q_col, r_q_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (w_adv) begin
            r_q_vld <= r_dv_vld[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_side <= r_dv_side[DIV_W];
            r_q_col  <= n_col;
            r_q_row  <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Address stages: row times column count, then add and range check
    // ------------------------------------------------------------------
    logic                   r_m1_vld;
    t_side                  r_m1_side;
    logic signed [RC_W-1:0] r_m1_rc;
    logic signed [31:0]     r_m1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_side <= r_q_side;
            r_m1_rc   <= r_q_row * $signed({1'b0, r_cols});
            r_m1_col  <= r_q_col;
        end
    end

    logic signed [IDX_W-1:0] w_idx;
    logic [IDX_W-2:0]        w_idx_mag;
    logic [20:0]             w_lim;
    logic                    w_in_range;
    logic                    w_pix_ok;

    assign w_idx      = IDX_W'(r_m1_rc) + IDX_W'(r_m1_col);
    assign w_idx_mag  = w_idx[IDX_W-2:0];
    assign w_lim      = r_rows * r_cols;
    assign w_in_range = !w_idx[IDX_W-1] && (w_idx_mag < (IDX_W-1)'(w_lim)) &&
                        (w_idx_mag < (IDX_W-1)'(NPIX));
    assign w_pix_ok   = 32'(r_m1_side.pixel_index) < NPIX;

    logic              r_m2_vld;
    logic              r_m2_wr;
    logic              r_m2_rd;
    logic [ADDR_W-1:0] r_m2_addr;
    logic [23:0]       r_m2_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (w_adv) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    // Pixel loads take the loaded address, projections the computed one
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_rgb <= r_m1_side.rgb;
            r_m2_wr  <= (r_m1_side.cmd == CMD_PIXEL) && w_pix_ok;
            r_m2_rd  <= !r_m1_side.drop && w_in_range;
            if (r_m1_side.cmd == CMD_PIXEL) begin
                r_m2_addr <= ADDR_W'(r_m1_side.pixel_index);
            end else begin
                r_m2_addr <= w_idx_mag[ADDR_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Image store: one write or one read per item
    // ------------------------------------------------------------------
    logic [23:0] r_mem [NPIX];
    logic [23:0] r_mem_pix;
    logic        r_mem_vld;
    logic        r_mem_hit;

    always_ff @(posedge i_clk) begin
        if (w_adv && r_m2_vld && r_m2_wr) begin
            r_mem[r_m2_addr] <= r_m2_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mem_pix <= r_mem[r_m2_addr];
            r_mem_hit <= r_m2_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= 1'b0;
        end else if (w_adv) begin
            r_mem_vld <= r_m2_vld;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        r_out_colored;
    logic [23:0] r_out_rgb;
    logic        w_colored;

    assign w_colored = r_mem_hit && (r_mem_pix != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_mem_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_colored <= w_colored;
            r_out_rgb     <= w_colored ? r_mem_pix : '0;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_colored   = r_out_colored;
    assign o_out_red   = r_out_rgb[23:16];
    assign o_out_green = r_out_rgb[15:8];
    assign o_out_blue  = r_out_rgb[7:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_colored_nonblack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_colored |-> (r_out_rgb != '0))
        else $error("colored result carries a black pixel");

    a_uncolored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_colored |-> (r_out_rgb == '0))
        else $error("uncolored result carries a color");

    a_no_rd_and_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m2_vld |-> !(r_m2_rd && r_m2_wr))
        else $error("item both reads and writes the image store");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_m2_vld) && $stable(r_mem_vld) && $stable(r_dv_vld[0]))
        else $error("pipeline moved while the output was stalled");

endmodule
